/* src/ace_pkg.sv */
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants of the ARP cache engine: table size, ARP field
// constants, status codes, register indices and the structs that travel
// along the row of table cells.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [10:0] MIN_LEN    = 11'd28;
  localparam logic [15:0] HTYPE_ETH  = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [7:0]  HLEN_ETH   = 8'd6;
  localparam logic [7:0]  PLEN_IPV4  = 8'd4;

  localparam logic OPER_PACKET = 1'b0;
  localparam logic OPER_LOOKUP = 1'b1;

  // Register indices, taken from paddr[3].
  localparam logic REG_HOST_IP = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  typedef enum logic [2:0] {
    ST_SHORT    = 3'd0,
    ST_BADTYPE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_INSERTED = 3'd4,
    ST_HIT      = 3'd5,
    ST_MISS     = 3'd6
  } status_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic [31:0]      key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [47:0]      hit_mac;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } token_t;

  // Write broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } wr_t;

  typedef struct packed {
    status_t     status;
    logic        reply_valid;
    logic [31:0] reply_target_ip;
    logic [47:0] reply_target_mac;
    logic [47:0] mac_result;
    logic        length_mismatch;
  } result_t;

endpackage

/* src/arp_cache_engine.sv */
// Items pass one at a time: the search token enters the head register, walks the row
// of cells, and the result goes through the result register into the output register.
// A new item is taken only once the previous result has moved to the output register; a waiting result does not
// block the next input transfer, it only holds the finish of the following item.
// Reset (rst_n, synchronous, active low) clears all valid bits at once;
// there is no clearing pass. Host registers reset to zero.
// ----------------------------------------------------------------------------
// arp_cache_engine
// Fully associative ARP cache built as a row of entry cells. A search token
// walks the row, picking up a matching entry and the lowest free slot; the
// controller then decides the outcome and broadcasts at most one write.
// ----------------------------------------------------------------------------
module arp_cache_engine
  import ace_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [10:0] in_packet_length,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_addr_len,
  input  logic [7:0]  in_proto_addr_len,
  input  logic [15:0] in_arp_opcode,
  input  logic [47:0] in_sender_mac,
  input  logic [31:0] in_sender_ip,
  input  logic [31:0] in_lookup_ip,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_reply_valid,
  output logic [31:0] out_reply_target_ip,
  output logic [47:0] out_reply_target_mac,
  output logic [47:0] out_mac_result,
  output logic        out_length_mismatch,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t  state_r;
  logic    in_xfer;

  // Item fields held for the decision at the end of the row.
  logic        op_r;
  logic [10:0] len_r;
  logic [15:0] htype_r;
  logic [15:0] ptype_r;
  logic [7:0]  hlen_r;
  logic [7:0]  plen_r;
  logic [15:0] opcode_r;
  logic [47:0] smac_r;
  logic [31:0] sip_r;

  token_t  tok_head_r;
  token_t  tok_head_nxt;
  token_t  tok_link [TABLE_ENTRIES+1];
  token_t  tok_tail;
  wr_t     wr_r;
  wr_t     wr_nxt;
  result_t res_r;
  result_t res_nxt;
  result_t out_r;
  logic    out_valid_r;

  logic [31:0] host_ip_r;
  logic [47:0] own_mac_r;

  // --------------------------------------------------------------------------
  // Configuration registers. Only bit 3 of the address selects a register;
  // a write completes in the access phase and pready is always high.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_ip_r <= '0;
      own_mac_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_HOST_IP: host_ip_r <= pwdata[31:0];
        REG_OWN_MAC: own_mac_r <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_HOST_IP: prdata = {32'd0, host_ip_r};
      REG_OWN_MAC: prdata = {16'd0, own_mac_r};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Row of entry cells. The token enters at cell 0 the cycle after the input
  // transfer and passes through every cell's register before it leaves the last cell.
  // --------------------------------------------------------------------------
  assign tok_link[0] = tok_head_r;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ace_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_in   (tok_link[i]),
      .wr       (wr_r),
      .tok_out  (tok_link[i+1])
    );
  end

  assign tok_tail = tok_link[TABLE_ENTRIES];

  // --------------------------------------------------------------------------
  // Outcome of the search. An update rewrites the matching entry; an insert
  // claims the lowest free slot. A full table stores nothing and sends no
  // reply, but still reports the length warning.
  // --------------------------------------------------------------------------
  always_comb begin
    res_nxt        = '0;
    res_nxt.status = ST_MISS;
    wr_nxt         = '0;
    wr_nxt.ip      = sip_r;
    wr_nxt.mac     = smac_r;
    if (op_r == OPER_LOOKUP) begin
      if (tok_tail.hit) begin
        res_nxt.status     = ST_HIT;
        res_nxt.mac_result = tok_tail.hit_mac;
      end else begin
        res_nxt.status = ST_MISS;
      end
    end else if (len_r < MIN_LEN) begin
      res_nxt.status = ST_SHORT;
    end else if ((htype_r != HTYPE_ETH) || (ptype_r != PTYPE_IPV4)) begin
      res_nxt.status = ST_BADTYPE;
    end else begin
      res_nxt.length_mismatch = (hlen_r != HLEN_ETH) || (plen_r != PLEN_IPV4);
      priority if (tok_tail.hit) begin
        res_nxt.status     = ST_UPDATED;
        res_nxt.mac_result = tok_tail.hit_mac;
        wr_nxt.en          = 1'b1;
        wr_nxt.idx         = tok_tail.hit_idx;
      end else if (tok_tail.free) begin
        res_nxt.status = ST_INSERTED;
        wr_nxt.en      = 1'b1;
        wr_nxt.idx     = tok_tail.free_idx;
      end else begin
        res_nxt.status = ST_FULL;
      end
      if (wr_nxt.en && (opcode_r == OP_REQUEST)) begin
        res_nxt.reply_valid      = 1'b1;
        res_nxt.reply_target_ip  = sip_r;
        res_nxt.reply_target_mac = smac_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. A new input transfer is taken whenever the sequencer is idle,
  // even while the previous result still waits in the output register.
  // --------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // The token is live at the head of the row for one cycle only, the cycle
  // after the input transfer.
  always_comb begin
    tok_head_nxt        = '0;
    tok_head_nxt.active = in_xfer;
    tok_head_nxt.key    = (in_operation == OPER_LOOKUP) ? in_lookup_ip : in_sender_ip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tok_head_r  <= '0;
      wr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tok_head_r <= tok_head_nxt;
      // The table write is issued for one cycle, when the token leaves the row.
      wr_r       <= ((state_r == S_SEARCH) && tok_tail.active) ? wr_nxt : '0;
      if ((state_r == S_FINISH) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r     <= in_operation;
            len_r    <= in_packet_length;
            htype_r  <= in_hw_type;
            ptype_r  <= in_proto_type;
            hlen_r   <= in_hw_addr_len;
            plen_r   <= in_proto_addr_len;
            opcode_r <= in_arp_opcode;
            smac_r   <= in_sender_mac;
            sip_r    <= in_sender_ip;
            state_r  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tok_tail.active) begin
            res_r   <= res_nxt;
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_r.status;
  assign out_reply_valid      = out_r.reply_valid;
  assign out_reply_target_ip  = out_r.reply_target_ip;
  assign out_reply_target_mac = out_r.reply_target_mac;
  assign out_mac_result       = out_r.mac_result;
  assign out_length_mismatch  = out_r.length_mismatch;

endmodule

/* src/ace_cell.sv */
// ----------------------------------------------------------------------------
// ace_cell
// One table entry. Compares the passing search token against its own entry,
// marks a hit or the first free slot, and hands the token on through its own register.
// ----------------------------------------------------------------------------
module ace_cell
  import ace_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  token_t           tok_in,
  input  wr_t              wr,
  output token_t           tok_out
);

  logic        valid_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  token_t      tok_r;
  token_t      tok_nxt;
  logic        wr_sel;

  assign wr_sel = wr.en && (wr.idx == cell_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active) begin
      if (!tok_in.hit && valid_r && (ip_r == tok_in.key)) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_idx = cell_idx;
        tok_nxt.hit_mac = mac_r;
      end
      if (!tok_in.free && !valid_r) begin
        tok_nxt.free     = 1'b1;
        tok_nxt.free_idx = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_sel) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      ip_r  <= wr.ip;
      mac_r <= wr.mac;
    end
  end

  assign tok_out = tok_r;

endmodule

/* src/ace_checker.sv */
// ----------------------------------------------------------------------------
// ace_checker
// Port-level checks on the result channel of the ARP cache engine.
// ----------------------------------------------------------------------------
module ace_checker
  import ace_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_reply_valid,
  input logic [31:0] out_reply_target_ip,
  input logic [47:0] out_reply_target_mac,
  input logic [47:0] out_mac_result,
  input logic        out_length_mismatch
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_mac_result) && $stable(out_reply_valid))
    else $error("result changed while stalled");

  // Replies only follow a packet that was stored.
  a_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_valid |->
      (out_status == ST_UPDATED) || (out_status == ST_INSERTED))
    else $error("reply without a stored packet");

  // Reply fields are zero when no reply is sent.
  a_noreply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reply_valid |->
      (out_reply_target_ip == '0) && (out_reply_target_mac == '0))
    else $error("reply fields set without a reply");

  // The MAC result is zero unless an entry was found.
  a_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_HIT) && (out_status != ST_UPDATED) |->
      (out_mac_result == '0))
    else $error("MAC result set without a match");

  // Lookups and packets dropped as short or of bad type never carry the length warning.
  a_warn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_SHORT) || (out_status == ST_BADTYPE)
      || (out_status == ST_HIT) || (out_status == ST_MISS)) |->
      !out_length_mismatch)
    else $error("length warning on a lookup or dropped packet");

endmodule

bind arp_cache_engine ace_checker u_ace_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_status           (out_status),
  .out_reply_valid      (out_reply_valid),
  .out_reply_target_ip  (out_reply_target_ip),
  .out_reply_target_mac (out_reply_target_mac),
  .out_mac_result       (out_mac_result),
  .out_length_mismatch  (out_length_mismatch)
);
